// ----- rtl/core/bitmap_glyph_column_renderer_macros.svh -----
// Assertion macros for the glyph column renderer.
// Needs signals named clock and reset in the including module.
`ifndef BITMAP_GLYPH_COLUMN_RENDERER_MACROS_SVH
`define BITMAP_GLYPH_COLUMN_RENDERER_MACROS_SVH

// same-cycle implication, checked out of reset
`define BGCR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bgcr check failed");

// next-cycle implication, checked out of reset
`define BGCR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bgcr check failed");

`endif

// ----- rtl/core/bgcr_pkg.sv -----
// Package for the glyph column renderer: sizes, codes, state and bus types.
// No dependencies; every module of the block but bgcr_ram imports it.
`timescale 1ns / 1ps

package bgcr_pkg;

   localparam int GLYPH_BYTES     = 4096;
   localparam int TABLE_ENTRIES   = 256;
   localparam int WIDTH_CAP       = 32;
   localparam int MAX_HEIGHT      = 32;
   localparam int COORD_BITS      = 12;
   localparam int GLYPH_ADDR_BITS = $clog2(GLYPH_BYTES);
   localparam int TABLE_IDX_BITS  = $clog2(TABLE_ENTRIES);
   localparam int PIX_BITS        = 32;
   localparam int NUM_REGS        = 8;
   localparam int CSR_ADDR_BITS   = $clog2(NUM_REGS * 4);
   localparam logic [7:0] CODE_MAX = 8'h80;
   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_GLYPH = 2'd1,
      KIND_ENTRY = 2'd2,
      KIND_DRAW  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_MODE        = 3'd0,
      REG_FIXED_WIDTH = 3'd1,
      REG_HEIGHT      = 3'd2,
      REG_FIRST_CODE  = 3'd3,
      REG_ORIGIN_X    = 3'd4,
      REG_ORIGIN_Y    = 3'd5,
      REG_CLIP_RIGHT  = 3'd6,
      REG_CLIP_BOTTOM = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_BASE,
      ST_COL,
      ST_READ,
      ST_ACCUM,
      ST_EMIT,
      ST_PEN
   } state_type;

   typedef struct packed {
      logic                  fixed_width_mode;
      logic [5:0]            fixed_glyph_width;
      logic [5:0]            glyph_height;
      logic [7:0]            first_code;
      logic [COORD_BITS-1:0] origin_x;
      logic [COORD_BITS-1:0] origin_y;
      logic [COORD_BITS-1:0] clip_right;
      logic [COORD_BITS-1:0] clip_bottom;
   } cfg_type;

   typedef struct packed {
      logic [11:0] offset;
      logic [5:0]  width;
   } tbl_entry_type;

   typedef struct packed {
      logic                       glyph_we;
      logic [GLYPH_ADDR_BITS-1:0] glyph_waddr;
      logic [7:0]                 glyph_wdata;
      logic                       glyph_re;
      logic [GLYPH_ADDR_BITS-1:0] glyph_raddr;
      logic                       table_we;
      logic [TABLE_IDX_BITS-1:0]  table_waddr;
      tbl_entry_type              table_wdata;
      logic                       table_re;
      logic [TABLE_IDX_BITS-1:0]  table_raddr;
   } mem_ctl_type;

endpackage

// ----- rtl/core/bgcr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the glyph store and the glyph table.
`timescale 1ns / 1ps

module bgcr_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bgcr_csr.sv -----
// Configuration register file behind the APB-style port.
// Depends on bgcr_pkg for the register indexes and the cfg_type bundle.
`timescale 1ns / 1ps

module bgcr_csr
   import bgcr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_MODE:        cfg_in.fixed_width_mode  = csr_pwdata[0];
            REG_FIXED_WIDTH: cfg_in.fixed_glyph_width = csr_pwdata[5:0];
            REG_HEIGHT:      cfg_in.glyph_height      = csr_pwdata[5:0];
            REG_FIRST_CODE:  cfg_in.first_code        = csr_pwdata[7:0];
            REG_ORIGIN_X:    cfg_in.origin_x          = csr_pwdata[COORD_BITS-1:0];
            REG_ORIGIN_Y:    cfg_in.origin_y          = csr_pwdata[COORD_BITS-1:0];
            REG_CLIP_RIGHT:  cfg_in.clip_right        = csr_pwdata[COORD_BITS-1:0];
            REG_CLIP_BOTTOM: cfg_in.clip_bottom       = csr_pwdata[COORD_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_MODE:        csr_prdata = 32'(cfg_ff.fixed_width_mode);
         REG_FIXED_WIDTH: csr_prdata = 32'(cfg_ff.fixed_glyph_width);
         REG_HEIGHT:      csr_prdata = 32'(cfg_ff.glyph_height);
         REG_FIRST_CODE:  csr_prdata = 32'(cfg_ff.first_code);
         REG_ORIGIN_X:    csr_prdata = 32'(cfg_ff.origin_x);
         REG_ORIGIN_Y:    csr_prdata = 32'(cfg_ff.origin_y);
         REG_CLIP_RIGHT:  csr_prdata = 32'(cfg_ff.clip_right);
         REG_CLIP_BOTTOM: csr_prdata = 32'(cfg_ff.clip_bottom);
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fixed_width_mode  <= 1'b1;
         cfg_ff.fixed_glyph_width <= 6'd8;
         cfg_ff.glyph_height      <= 6'd16;
         cfg_ff.first_code        <= 8'd0;
         cfg_ff.origin_x          <= '0;
         cfg_ff.origin_y          <= '0;
         cfg_ff.clip_right        <= COORD_MAX;
         cfg_ff.clip_bottom       <= COORD_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/bgcr_seq.sv -----
// Request sequencer with the shared 12+6 bit adder, column loop and result register.
// Depends on bgcr_pkg and the assertion macros; drives both RAMs through mem_ctl.
`timescale 1ns / 1ps
`include "bitmap_glyph_column_renderer_macros.svh"

module bgcr_seq
   import bgcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  logic [11:0]           req_address,
   input  logic [7:0]            req_glyph_byte,
   input  logic [11:0]           req_entry_offset,
   input  logic [5:0]            req_entry_width,
   input  logic [7:0]            req_char_code,
   output mem_ctl_type           mem_ctl,
   input  logic [7:0]            glyph_rd_data,
   input  tbl_entry_type         table_rd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_column_x,
   output logic [COORD_BITS-1:0] rsp_column_top_y,
   output logic [PIX_BITS-1:0]   rsp_column_pixels,
   output logic                  rsp_last
);

   state_type             state_ff, state_in;
   logic [COORD_BITS-1:0] pen_ff, pen_in;
   logic [7:0]            idx_ff, idx_in;
   logic [5:0]            width_ff, width_in;
   logic [2:0]            pages_ff, pages_in;
   logic [8:0]            wp_ff, wp_in;
   logic [PIX_BITS-1:0]   mask_ff, mask_in;
   logic [11:0]           start_ff, start_in;
   logic [11:0]           addr_ff, addr_in;
   logic [COORD_BITS:0]   x_ff, x_in;
   logic [5:0]            col_ff, col_in;
   logic [1:0]            page_ff, page_in;
   logic [PIX_BITS-1:0]   pix_ff, pix_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic [PIX_BITS-1:0]   rsp_pix_ff, rsp_pix_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   kind_type              kind;
   logic                  code_ok;
   logic [7:0]            code_diff;
   logic [5:0]            height_lim;
   logic [2:0]            pages_calc;
   logic [5:0]            width_raw;
   logic [5:0]            width_lim;
   logic [COORD_BITS-1:0] row_span;
   logic [PIX_BITS-1:0]   mask_calc;
   logic [16:0]           base_prod;
   logic [11:0]           add_a;
   logic [5:0]            add_b;
   logic [12:0]           add_sum;
   logic                  slot_free;
   logic                  emit;

   assign accept    = req_valid & req_ready;
   assign kind      = kind_type'(req_kind);
   assign code_ok   = (req_char_code <= CODE_MAX) && (req_char_code >= cfg.first_code);
   assign code_diff = req_char_code - cfg.first_code;
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign emit      = (state_ff == ST_EMIT) & slot_free;

   assign height_lim = (cfg.glyph_height > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : cfg.glyph_height;
   assign pages_calc = 3'((7'(height_lim) + 7'd7) >> 3);
   assign width_raw  = cfg.fixed_width_mode ? cfg.fixed_glyph_width : table_rd_data.width;
   assign width_lim  = (width_raw > 6'(WIDTH_CAP)) ? 6'(WIDTH_CAP) : width_raw;
   assign row_span   = cfg.clip_bottom - cfg.origin_y;
   assign base_prod  = 17'(idx_ff) * 17'(wp_ff);

   always_comb begin
      if (cfg.origin_y > cfg.clip_bottom) begin
         mask_calc = '0;
      end else if (row_span >= COORD_BITS'(PIX_BITS - 1)) begin
         mask_calc = '1;
      end else begin
         mask_calc = {PIX_BITS{1'b1}} >> (5'(PIX_BITS - 1) - row_span[4:0]);
      end
   end

   // shared adder: column base, page address step and pen advance
   always_comb begin
      case (state_ff)
         ST_READ: begin
            add_a = addr_ff;
            add_b = width_ff;
         end
         ST_PEN: begin
            add_a = pen_ff;
            add_b = width_ff;
         end
         default: begin
            add_a = start_ff;
            add_b = col_ff;
         end
      endcase
      add_sum = {1'b0, add_a} + 13'(add_b);
   end

   always_comb begin
      mem_ctl.glyph_we    = accept && (kind == KIND_GLYPH) && (32'(req_address) < GLYPH_BYTES);
      mem_ctl.glyph_waddr = req_address[GLYPH_ADDR_BITS-1:0];
      mem_ctl.glyph_wdata = req_glyph_byte;
      mem_ctl.glyph_re    = (state_ff == ST_READ);
      mem_ctl.glyph_raddr = addr_ff[GLYPH_ADDR_BITS-1:0];
      mem_ctl.table_we    = accept && (kind == KIND_ENTRY) &&
                            (32'(req_address) < TABLE_ENTRIES);
      mem_ctl.table_waddr = req_address[TABLE_IDX_BITS-1:0];
      mem_ctl.table_wdata.offset = req_entry_offset;
      mem_ctl.table_wdata.width  = req_entry_width;
      mem_ctl.table_re    = accept && (kind == KIND_DRAW);
      mem_ctl.table_raddr = code_diff[TABLE_IDX_BITS-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      pen_in       = pen_ff;
      idx_in       = idx_ff;
      width_in     = width_ff;
      pages_in     = pages_ff;
      wp_in        = wp_ff;
      mask_in      = mask_ff;
      start_in     = start_ff;
      addr_in      = addr_ff;
      x_in         = x_ff;
      col_in       = col_ff;
      page_in      = page_ff;
      pix_in       = pix_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_last_in  = rsp_last_ff;
      req_ready    = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (kind)
                  KIND_START: pen_in = cfg.origin_x;
                  KIND_DRAW: begin
                     if (code_ok) begin
                        idx_in   = code_diff;
                        state_in = ST_SETUP;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP: begin
            width_in = width_lim;
            pages_in = pages_calc;
            wp_in    = 9'(width_lim) * 9'(pages_calc);
            mask_in  = mask_calc;
            start_in = table_rd_data.offset;
            x_in     = {1'b0, pen_ff};
            col_in   = '0;
            if (cfg.fixed_width_mode) begin
               state_in = ST_BASE;
            end else if (32'(idx_ff) >= TABLE_ENTRIES) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_COL;
            end
         end
         ST_BASE: begin
            start_in = base_prod[11:0];
            state_in = ST_COL;
         end
         ST_COL: begin
            if ((col_ff == width_ff) || (x_ff > {1'b0, cfg.clip_right})) begin
               state_in = ST_PEN;
            end else begin
               addr_in  = add_sum[11:0];
               page_in  = '0;
               pix_in   = '0;
               state_in = (pages_ff == 3'd0) ? ST_EMIT : ST_READ;
            end
         end
         ST_READ: begin
            addr_in  = add_sum[11:0];
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            pix_in[{page_ff, 3'b000} +: 8] = glyph_rd_data;
            page_in = page_ff + 2'd1;
            state_in = (({1'b0, page_ff} + 3'd1) == pages_ff) ? ST_EMIT : ST_READ;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_ff[COORD_BITS-1:0];
               rsp_y_in     = cfg.origin_y;
               rsp_pix_in   = pix_ff & mask_ff;
               rsp_last_in  = (col_ff == (width_ff - 6'd1)) ||
                              (x_ff[COORD_BITS-1:0] == cfg.clip_right);
               col_in       = col_ff + 6'd1;
               x_in         = x_ff + 13'd1;
               state_in     = ST_COL;
            end
         end
         ST_PEN: begin
            pen_in   = add_sum[12] ? COORD_MAX : add_sum[11:0];
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_ff       <= pen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      width_ff    <= width_in;
      pages_ff    <= pages_in;
      wp_ff       <= wp_in;
      mask_ff     <= mask_in;
      start_ff    <= start_in;
      addr_ff     <= addr_in;
      x_ff        <= x_in;
      col_ff      <= col_in;
      page_ff     <= page_in;
      pix_ff      <= pix_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column_x      = rsp_x_ff;
   assign rsp_column_top_y  = rsp_y_ff;
   assign rsp_column_pixels = rsp_pix_ff;
   assign rsp_last          = rsp_last_ff;

   `BGCR_ASSERT_NEXT(a_read_then_accum, state_ff == ST_READ, state_ff == ST_ACCUM)
   `BGCR_ASSERT_NOW(a_page_in_range, state_ff == ST_ACCUM, {1'b0, page_ff} < pages_ff)
   `BGCR_ASSERT_NEXT(a_emit_loads_rsp, emit, rsp_valid_ff && (col_ff == $past(col_ff) + 6'd1))
   `BGCR_ASSERT_NEXT(a_pen_forward, state_ff == ST_PEN,
                     (state_ff == ST_IDLE) && (pen_ff >= $past(pen_ff)))

endmodule

// ----- rtl/core/bitmap_glyph_column_renderer.sv -----
// Top level of the bitmap glyph column renderer.
// Depends on bgcr_pkg, bgcr_csr, bgcr_seq and two bgcr_ram instances.
//
//   port group  direction  handshake              carries
//   req_*       in         req_valid / req_ready  kind, address, byte, entry, code
//   rsp_*       out        rsp_valid / rsp_ready  column x, top y, pixels, last
//   csr_*       in/out     psel, penable, pready  8 config registers at 4*i
//
// Start, glyph and table requests are handled in IDLE as they are accepted. A draw
// is accepted, set up (plus the base multiply in fixed-width mode), then each
// emitted column is checked, read page by page and emitted; a closing column
// check and the pen update follow. No new request is accepted until then.
// The column loop is bound by the single read port of the glyph store.
// A full result register stalls the column loop; reset clears state, pen,
// result valid and configuration, not the stores.
`timescale 1ns / 1ps

module bitmap_glyph_column_renderer
   import bgcr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_kind,
   input  logic [11:0]              req_address,
   input  logic [7:0]               req_glyph_byte,
   input  logic [11:0]              req_entry_offset,
   input  logic [5:0]               req_entry_width,
   input  logic [7:0]               req_char_code,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COORD_BITS-1:0]    rsp_column_x,
   output logic [COORD_BITS-1:0]    rsp_column_top_y,
   output logic [PIX_BITS-1:0]      rsp_column_pixels,
   output logic                     rsp_last,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   cfg_type       cfg;
   mem_ctl_type   mem_ctl;
   logic [7:0]    glyph_rd_data;
   tbl_entry_type table_rd_data;

   bgcr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bgcr_ram #(
      .DEPTH (GLYPH_BYTES),
      .WIDTH (8)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.glyph_we),
      .wr_addr (mem_ctl.glyph_waddr),
      .wr_data (mem_ctl.glyph_wdata),
      .rd_en   (mem_ctl.glyph_re),
      .rd_addr (mem_ctl.glyph_raddr),
      .rd_data (glyph_rd_data)
   );

   bgcr_ram #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH ($bits(tbl_entry_type))
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (mem_ctl.table_we),
      .wr_addr (mem_ctl.table_waddr),
      .wr_data (mem_ctl.table_wdata),
      .rd_en   (mem_ctl.table_re),
      .rd_addr (mem_ctl.table_raddr),
      .rd_data (table_rd_data)
   );

   bgcr_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_address       (req_address),
      .req_glyph_byte    (req_glyph_byte),
      .req_entry_offset  (req_entry_offset),
      .req_entry_width   (req_entry_width),
      .req_char_code     (req_char_code),
      .mem_ctl           (mem_ctl),
      .glyph_rd_data     (glyph_rd_data),
      .table_rd_data     (table_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_column_x      (rsp_column_x),
      .rsp_column_top_y  (rsp_column_top_y),
      .rsp_column_pixels (rsp_column_pixels),
      .rsp_last          (rsp_last)
   );

endmodule

// ----- dv/testbench.sv -----
// Testbench for bitmap_glyph_column_renderer: loads the glyph store and table, then runs
// directed and random draws, checking every column against a predictor or a typed expectation.
// Depends on bgcr_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench
   import bgcr_pkg::*;
();

   typedef struct packed {
      kind_type    kind;
      logic [11:0] address;
      logic [7:0]  glyph_byte;
      logic [11:0] entry_offset;
      logic [5:0]  entry_width;
      logic [7:0]  char_code;
   } request_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] top_y;
      logic [PIX_BITS-1:0]   pixels;
      logic                  last;
   } column_type;

   typedef enum {FROM_MODEL, NO_COLUMNS, ONE_COLUMN} column_check_type;
   typedef enum {ROW_REQ, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type       op;
      request_type      item;
      reg_index_type    regi;
      logic [31:0]      value;
      column_check_type check;
      column_type       typed;
   } row_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_kind = '0;
   logic [11:0]              req_address = '0;
   logic [7:0]               req_glyph_byte = '0;
   logic [11:0]              req_entry_offset = '0;
   logic [5:0]               req_entry_width = '0;
   logic [7:0]               req_char_code = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [COORD_BITS-1:0]    rsp_column_x;
   logic [COORD_BITS-1:0]    rsp_column_top_y;
   logic [PIX_BITS-1:0]      rsp_column_pixels;
   logic                     rsp_last;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]              csr_pwdata = '0;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   logic [7:0]  glyph_copy [GLYPH_BYTES];
   logic [11:0] offset_copy [TABLE_ENTRIES];
   logic [5:0]  width_copy [TABLE_ENTRIES];
   int unsigned pen_copy = 0;
   cfg_type     cfg;

   column_type  drawn_columns[$];
   column_type  expected_columns[$];
   int unsigned mismatches = 0;
   bit          steady = 1'b0;
   bit          dirty = 1'b0;

   bitmap_glyph_column_renderer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_address       (req_address),
      .req_glyph_byte    (req_glyph_byte),
      .req_entry_offset  (req_entry_offset),
      .req_entry_width   (req_entry_width),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_column_x      (rsp_column_x),
      .rsp_column_top_y  (rsp_column_top_y),
      .rsp_column_pixels (rsp_column_pixels),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   function automatic void predict_columns(request_type item);
      int unsigned idx, wid, hgt, pages, start, rowmask, x, pix, i, c;
      column_type  col;
      drawn_columns.delete();
      case (item.kind)
         KIND_START: pen_copy = cfg.origin_x;
         KIND_GLYPH: glyph_copy[item.address] = item.glyph_byte;
         KIND_ENTRY: begin
            if (item.address < TABLE_ENTRIES) begin
               offset_copy[item.address[TABLE_IDX_BITS-1:0]] = item.entry_offset;
               width_copy[item.address[TABLE_IDX_BITS-1:0]] = item.entry_width;
            end
         end
         default: begin
            if (item.char_code > CODE_MAX || item.char_code < cfg.first_code) return;
            idx = item.char_code - cfg.first_code;
            hgt = (cfg.glyph_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg.glyph_height;
            pages = (hgt + 7) / 8;
            if (cfg.fixed_width_mode) begin
               wid = (cfg.fixed_glyph_width > WIDTH_CAP) ? WIDTH_CAP : cfg.fixed_glyph_width;
               start = idx * wid * pages;
            end else begin
               if (idx >= TABLE_ENTRIES) return;
               wid = (width_copy[TABLE_IDX_BITS'(idx)] > WIDTH_CAP) ? WIDTH_CAP
                                                                    : width_copy[TABLE_IDX_BITS'(idx)];
               start = offset_copy[TABLE_IDX_BITS'(idx)];
            end
            rowmask = 0;
            for (i = 0; i < PIX_BITS; i++)
               if (cfg.origin_y + i <= cfg.clip_bottom) rowmask[5'(i)] = 1'b1;
            for (i = 0; i < wid; i++) begin
               x = pen_copy + i;
               if (x > cfg.clip_right) continue;
               pix = 0;
               for (c = 0; c < pages; c++)
                  pix |= 32'(glyph_copy[GLYPH_ADDR_BITS'((start + i + c * wid) % GLYPH_BYTES)])
                         << (8 * c);
               col.x = x[COORD_BITS-1:0];
               col.top_y = cfg.origin_y;
               col.pixels = pix & rowmask;
               col.last = 1'b0;
               drawn_columns.push_back(col);
            end
            if (drawn_columns.size() > 0)
               drawn_columns[drawn_columns.size() - 1].last = 1'b1;
            pen_copy = (pen_copy + wid > COORD_MAX) ? COORD_MAX : pen_copy + wid;
         end
      endcase
   endfunction

   function automatic request_type random_request();
      request_type item;
      item.kind = kind_type'($urandom_range(3));
      item.address = 12'($urandom);
      item.glyph_byte = 8'($urandom);
      item.entry_offset = 12'($urandom);
      item.entry_width = ($urandom_range(7) == 0) ? 6'($urandom_range(63, 33))
                                                  : 6'($urandom_range(32));
      item.char_code = 8'($urandom);
      return item;
   endfunction

   function automatic row_type req_row(kind_type k, logic [11:0] a, logic [7:0] b,
                                       logic [11:0] o, logic [5:0] w, logic [7:0] c,
                                       column_check_type check);
      row_type r;
      r.op = ROW_REQ;
      r.item = '{k, a, b, o, w, c};
      r.regi = REG_MODE;
      r.value = '0;
      r.check = check;
      r.typed = '0;
      return r;
   endfunction

   function automatic row_type one_row(logic [7:0] c, logic [11:0] x, logic [11:0] y,
                                       logic [31:0] pix);
      row_type r;
      r = req_row(KIND_DRAW, 12'd0, 8'd0, 12'd0, 6'd0, c, ONE_COLUMN);
      r.typed = '{x, y, pix, 1'b1};
      return r;
   endfunction

   function automatic row_type csr_row(reg_index_type regi, logic [31:0] v);
      row_type r;
      r.op = ROW_CSR;
      r.item = '0;
      r.regi = regi;
      r.value = v;
      r.check = NO_COLUMNS;
      r.typed = '0;
      return r;
   endfunction

   task automatic send_request(request_type item, column_check_type check, column_type typed);
      while (!steady && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= item.kind;
      req_address <= item.address;
      req_glyph_byte <= item.glyph_byte;
      req_entry_offset <= item.entry_offset;
      req_entry_width <= item.entry_width;
      req_char_code <= item.char_code;
      do @(posedge clock); while (!req_ready);
      dirty = 1'b1;
      predict_columns(item);
      case (check)
         FROM_MODEL: foreach (drawn_columns[i]) expected_columns.push_back(drawn_columns[i]);
         ONE_COLUMN: expected_columns.push_back(typed);
         default: ;
      endcase
   endtask

   task automatic drain();
      int unsigned waited;
      if (!dirty) return;
      req_valid <= 1'b0;
      waited = 0;
      while (expected_columns.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (400) @(posedge clock);
      if (expected_columns.size() != 0) begin
         flag($sformatf("%0d columns never arrived", expected_columns.size()));
         expected_columns.delete();
      end
      dirty = 1'b0;
   endtask

   task automatic csr_write(reg_index_type regi, logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {regi, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (regi)
         REG_MODE:        cfg.fixed_width_mode = v[0];
         REG_FIXED_WIDTH: cfg.fixed_glyph_width = v[5:0];
         REG_HEIGHT:      cfg.glyph_height = v[5:0];
         REG_FIRST_CODE:  cfg.first_code = v[7:0];
         REG_ORIGIN_X:    cfg.origin_x = v[COORD_BITS-1:0];
         REG_ORIGIN_Y:    cfg.origin_y = v[COORD_BITS-1:0];
         REG_CLIP_RIGHT:  cfg.clip_right = v[COORD_BITS-1:0];
         default:         cfg.clip_bottom = v[COORD_BITS-1:0];
      endcase
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) rsp_ready <= steady || ($urandom_range(99) >= 27);

   always @(posedge clock) begin : check_columns
      column_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_columns.size() == 0) begin
            flag($sformatf("unexpected column x=%0d y=%0d pixels=%h last=%b",
                           rsp_column_x, rsp_column_top_y, rsp_column_pixels, rsp_last));
         end else begin
            want = expected_columns.pop_front();
            if (rsp_column_x !== want.x || rsp_column_top_y !== want.top_y ||
                rsp_column_pixels !== want.pixels || rsp_last !== want.last)
               flag($sformatf({"column mismatch: want x=%0d y=%0d pixels=%h last=%b,",
                               " got x=%0d y=%0d pixels=%h last=%b"},
                              want.x, want.top_y, want.pixels, want.last,
                              rsp_column_x, rsp_column_top_y, rsp_column_pixels, rsp_last));
         end
      end
   end

   initial begin : stimulus
      row_type     rows[$];
      request_type item;
      int unsigned phase, k, pick, a;
      logic        mode;
      logic [5:0]  fw, hgt;
      logic [7:0]  first;
      logic [11:0] ox, oy, cr, cb;
      logic [31:0] noise;

      cfg = '{1'b1, 6'd8, 6'd16, 8'd0, 12'd0, 12'd0, COORD_MAX, COORD_MAX};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (a = 0; a < GLYPH_BYTES; a++) begin
         item = random_request();
         item.kind = KIND_GLYPH;
         item.address = 12'(a);
         send_request(item, NO_COLUMNS, '0);
      end
      for (a = 0; a < TABLE_ENTRIES; a++) begin
         item = random_request();
         item.kind = KIND_ENTRY;
         item.address = 12'(a);
         send_request(item, NO_COLUMNS, '0);
      end

      rows.push_back(req_row(KIND_GLYPH, 12'd0, 8'hFF, 12'd0, 6'd0, 8'd0, NO_COLUMNS));
      rows.push_back(req_row(KIND_GLYPH, 12'd4095, 8'h00, 12'd0, 6'd0, 8'd0, NO_COLUMNS));
      rows.push_back(req_row(KIND_START, 12'd0, 8'd0, 12'd0, 6'd0, 8'd0, NO_COLUMNS));
      rows.push_back(req_row(KIND_DRAW, 12'd0, 8'd0, 12'd0, 6'd0, 8'h00, FROM_MODEL));
      rows.push_back(req_row(KIND_DRAW, 12'd0, 8'd0, 12'd0, 6'd0, 8'h80, FROM_MODEL));
      rows.push_back(req_row(KIND_DRAW, 12'd0, 8'd0, 12'd0, 6'd0, 8'h81, NO_COLUMNS));
      rows.push_back(req_row(KIND_DRAW, 12'd0, 8'd0, 12'd0, 6'd0, 8'hFF, NO_COLUMNS));
      rows.push_back(csr_row(REG_FIXED_WIDTH, 32'd1));
      rows.push_back(csr_row(REG_HEIGHT, 32'd8));
      rows.push_back(csr_row(REG_ORIGIN_X, 32'd4095));
      rows.push_back(csr_row(REG_ORIGIN_Y, 32'd4095));
      rows.push_back(req_row(KIND_START, 12'd0, 8'd0, 12'd0, 6'd0, 8'd0, NO_COLUMNS));
      rows.push_back(one_row(8'h00, 12'hFFF, 12'hFFF, 32'h1));
      rows.push_back(one_row(8'h00, 12'hFFF, 12'hFFF, 32'h1));
      rows.push_back(csr_row(REG_CLIP_RIGHT, 32'd0));
      rows.push_back(req_row(KIND_DRAW, 12'd0, 8'd0, 12'd0, 6'd0, 8'h00, NO_COLUMNS));
      rows.push_back(csr_row(REG_CLIP_RIGHT, 32'd4095));
      rows.push_back(csr_row(REG_FIRST_CODE, 32'd255));
      rows.push_back(req_row(KIND_DRAW, 12'd0, 8'd0, 12'd0, 6'd0, 8'h80, NO_COLUMNS));
      rows.push_back(csr_row(REG_FIRST_CODE, 32'd0));
      rows.push_back(csr_row(REG_HEIGHT, 32'd0));
      rows.push_back(one_row(8'h00, 12'hFFF, 12'hFFF, 32'h0));
      rows.push_back(csr_row(REG_CLIP_BOTTOM, 32'd0));
      rows.push_back(csr_row(REG_HEIGHT, 32'd63));
      rows.push_back(one_row(8'h00, 12'hFFF, 12'hFFF, 32'h0));
      rows.push_back(csr_row(REG_ORIGIN_X, 32'd0));
      rows.push_back(csr_row(REG_ORIGIN_Y, 32'd0));
      rows.push_back(csr_row(REG_CLIP_BOTTOM, 32'd4095));
      rows.push_back(csr_row(REG_MODE, 32'd0));
      rows.push_back(req_row(KIND_ENTRY, 12'd5, 8'd0, 12'd4095, 6'd63, 8'd0, NO_COLUMNS));
      rows.push_back(req_row(KIND_ENTRY, 12'd4095, 8'd0, 12'd0, 6'd0, 8'd0, NO_COLUMNS));
      rows.push_back(req_row(KIND_ENTRY, 12'd6, 8'd0, 12'd0, 6'd0, 8'd0, NO_COLUMNS));
      rows.push_back(req_row(KIND_ENTRY, 12'd7, 8'd0, 12'd0, 6'd1, 8'd0, NO_COLUMNS));
      rows.push_back(req_row(KIND_START, 12'd0, 8'd0, 12'd0, 6'd0, 8'd0, NO_COLUMNS));
      rows.push_back(req_row(KIND_DRAW, 12'd0, 8'd0, 12'd0, 6'd0, 8'd5, FROM_MODEL));
      rows.push_back(req_row(KIND_DRAW, 12'd0, 8'd0, 12'd0, 6'd0, 8'd6, NO_COLUMNS));
      rows.push_back(req_row(KIND_DRAW, 12'd0, 8'd0, 12'd0, 6'd0, 8'd7, FROM_MODEL));

      foreach (rows[i]) begin
         if (rows[i].op == ROW_CSR) begin
            drain();
            csr_write(rows[i].regi, rows[i].value);
         end else begin
            send_request(rows[i].item, rows[i].check, rows[i].typed);
         end
      end

      for (phase = 0; phase < 10; phase++) begin
         drain();
         steady = (phase == 6);
         case (phase)
            0: begin
               mode = 1'b1; fw = 6'd32; hgt = 6'd32; first = 8'd0;
               ox = 12'd0; oy = 12'd0; cr = COORD_MAX; cb = COORD_MAX;
            end
            1: begin
               mode = 1'b0; fw = 6'd1; hgt = 6'd1; first = 8'd32;
               ox = 12'd4000; oy = 12'd4095; cr = COORD_MAX; cb = COORD_MAX;
            end
            2: begin
               mode = 1'b1; fw = 6'd63; hgt = 6'd63; first = 8'd128;
               ox = 12'd0; oy = 12'd0; cr = 12'd0; cb = 12'd0;
            end
            3: begin
               mode = 1'b1; fw = 6'd0; hgt = 6'd8; first = 8'd0;
               ox = 12'd100; oy = 12'd10; cr = 12'd120; cb = 12'd15;
            end
            default: begin
               mode = 1'($urandom);
               fw = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 33))
                                             : 6'($urandom_range(32, 1));
               hgt = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                              : 6'($urandom_range(32, 1));
               first = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(40));
               ox = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(300));
               oy = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(300));
               cr = ($urandom_range(3) == 0) ? 12'($urandom) : COORD_MAX;
               cb = ($urandom_range(3) == 0) ? 12'($urandom) : COORD_MAX;
            end
         endcase
         noise = (phase > 3) ? ($urandom & 32'hFFFF_F000) : 32'd0;
         csr_write(REG_MODE, noise | 32'(mode));
         csr_write(REG_FIXED_WIDTH, noise | 32'(fw));
         csr_write(REG_HEIGHT, noise | 32'(hgt));
         csr_write(REG_FIRST_CODE, noise | 32'(first));
         csr_write(REG_ORIGIN_X, noise | 32'(ox));
         csr_write(REG_ORIGIN_Y, noise | 32'(oy));
         csr_write(REG_CLIP_RIGHT, noise | 32'(cr));
         csr_write(REG_CLIP_BOTTOM, noise | 32'(cb));

         for (k = 0; k < 16; k++) begin
            item = random_request();
            pick = (k == 0) ? 0 : $urandom_range(99);
            if (pick < 8) begin
               item.kind = KIND_START;
            end else if (pick < 18) begin
               item.kind = KIND_GLYPH;
            end else if (pick < 28) begin
               item.kind = KIND_ENTRY;
               if ($urandom_range(3) != 0) item.address = 12'($urandom_range(255));
            end else if (pick < 34) begin
               item.kind = KIND_DRAW;
            end else begin
               item.kind = KIND_DRAW;
               if (cfg.first_code <= CODE_MAX)
                  item.char_code = 8'($urandom_range(CODE_MAX, cfg.first_code));
            end
            send_request(item, FROM_MODEL, '0);
         end
      end
      steady = 1'b0;
      drain();

      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
